// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by the checker file
// each expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TFU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tfu_pkg.sv -----
package tfu_pkg;

    // command codes
    localparam logic [1:0] FUNC_MOVE      = 2'd0;
    localparam logic [1:0] FUNC_TURN_UP   = 2'd1;
    localparam logic [1:0] FUNC_TURN_LEFT = 2'd2;
    localparam logic [1:0] FUNC_TURN_FWD  = 2'd3;

    // frame axis index
    localparam logic [1:0] AXIS_FWD = 2'd0;
    localparam logic [1:0] AXIS_LFT = 2'd1;
    localparam logic [1:0] AXIS_UP  = 2'd2;

    // products through the shared multiplier per command
    localparam logic [3:0] MOVE_PRODUCTS = 4'd3;
    localparam logic [3:0] TURN_PRODUCTS = 4'd12;

    // angle units of 2^-16 degree
    localparam int DEG_ONE      = 65536;
    localparam int FULL_TURN    = 360 * DEG_ONE;
    localparam int HALF_TURN    = 180 * DEG_ONE;
    localparam int QUARTER_TURN = 90 * DEG_ONE;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int UNIT_Q14     = 16384;

    localparam logic [33:0] FULL_TURN_W = 34'(FULL_TURN);
    // 128 full turns, lifts any negative 32-bit angle above zero
    localparam logic [33:0] WRAP_OFFSET = FULL_TURN_W << 7;
    localparam logic signed [25:0] FULL_TURN_Z    = 26'(FULL_TURN);
    localparam logic signed [25:0] HALF_TURN_Z    = 26'(HALF_TURN);
    localparam logic signed [25:0] QUARTER_TURN_Z = 26'(QUARTER_TURN);

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_REDUCE,
        SC_FOLD,
        SC_ROTATE,
        SC_ROUND
    } sc_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SINCOS,
        T_MAC,
        T_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        MAC_NONE,
        MAC_MOVE,
        MAC_LOAD_A,
        MAC_LOAD_B,
        MAC_FIN_A,
        MAC_FIN_B
    } mac_op_t;

    typedef struct packed {
        logic    mul_en;
        mac_op_t op;
    } mac_ctrl_t;

    // arctangent of 2^-i in units of 2^-16 degree
    function automatic logic signed [25:0] atan_deg(input logic [3:0] idx);
        logic signed [25:0] v;
        case (idx)
            4'd0:  v = 26'sd2949120;
            4'd1:  v = 26'sd1740967;
            4'd2:  v = 26'sd919879;
            4'd3:  v = 26'sd466945;
            4'd4:  v = 26'sd234379;
            4'd5:  v = 26'sd117304;
            4'd6:  v = 26'sd58666;
            4'd7:  v = 26'sd29335;
            4'd8:  v = 26'sd14668;
            4'd9:  v = 26'sd7334;
            4'd10: v = 26'sd3667;
            4'd11: v = 26'sd1833;
            4'd12: v = 26'sd917;
            4'd13: v = 26'sd458;
            4'd14: v = 26'sd229;
            default: v = 26'sd115;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
            r = 16'sh7fff;
        else if (v < -20'sd32768)
            r = -16'sd32768;
        else
            r = 16'(v);
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(v);
        return r;
    endfunction

endpackage

// ----- rtl/core/tfu_sincos.sv -----
module tfu_sincos (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] amount,
    output logic               done,
    output logic signed [15:0] cos_val,
    output logic signed [15:0] sin_val
);
    import tfu_pkg::*;

    sc_state_t state_reg, state_next;

    logic [3:0]         step_reg, step_next;
    logic [33:0]        r_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [25:0] z_reg;
    logic               neg_reg;

    logic [33:0]        amt_ext;
    logic [33:0]        wrap_step;
    logic signed [25:0] r_mod_s, r_ctr, z_fold;
    logic               neg_fold;
    logic signed [33:0] dx, dy;
    logic signed [25:0] ang;
    logic signed [17:0] x_rnd, y_rnd;
    logic signed [15:0] x_cl, y_cl;

    function automatic logic signed [15:0] clamp_unit(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'(UNIT_Q14))
            r = 16'(UNIT_Q14);
        else if (v < -18'(UNIT_Q14))
            r = -16'(UNIT_Q14);
        else
            r = 16'(v);
        return r;
    endfunction

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // sequencer: reduce, fold, rotate, round
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done       = 1'b0;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    state_next = SC_REDUCE;
                    step_next  = 4'd7;
                end
            end
            SC_REDUCE:
            begin
                if (step_reg[2:0] == 3'd0)
                    state_next = SC_FOLD;
                else
                    step_next = step_reg - 4'd1;
            end
            SC_FOLD:
            begin
                state_next = SC_ROTATE;
                step_next  = '0;
            end
            SC_ROTATE:
            begin
                if (step_reg == 4'(CORDIC_STEPS - 1))
                    state_next = SC_ROUND;
                else
                    step_next = step_reg + 4'd1;
            end
            SC_ROUND:
            begin
                done       = 1'b1;
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    // modulo by restoring subtraction of shifted full turns
    assign amt_ext   = {{2{amount[31]}}, amount};
    assign wrap_step = FULL_TURN_W << step_reg[2:0];

    // fold into [-90, 90] degrees
    always_comb
    begin
        r_mod_s  = signed'({1'b0, r_reg[24:0]});
        r_ctr    = (r_mod_s >= HALF_TURN_Z) ? r_mod_s - FULL_TURN_Z : r_mod_s;
        z_fold   = r_ctr;
        neg_fold = 1'b0;
        if (r_ctr > QUARTER_TURN_Z)
        begin
            z_fold   = r_ctr - HALF_TURN_Z;
            neg_fold = 1'b1;
        end
        else if (r_ctr < -QUARTER_TURN_Z)
        begin
            z_fold   = r_ctr + HALF_TURN_Z;
            neg_fold = 1'b1;
        end
    end

    // one cordic micro-rotation
    assign dx  = y_reg >>> step_reg;
    assign dy  = x_reg >>> step_reg;
    assign ang = atan_deg(step_reg);

    // shared datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                    r_reg <= amount[31] ? amt_ext + WRAP_OFFSET : amt_ext;
            end
            SC_REDUCE:
            begin
                if (r_reg >= wrap_step)
                    r_reg <= r_reg - wrap_step;
            end
            SC_FOLD:
            begin
                x_reg   <= 34'(CORDIC_GAIN);
                y_reg   <= '0;
                z_reg   <= z_fold;
                neg_reg <= neg_fold;
            end
            SC_ROTATE:
            begin
                if (!z_reg[25])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - ang;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + ang;
                end
            end
            default:
            begin
            end
        endcase
    end

    // round to q2.14, clamp, restore sign
    assign x_rnd   = 18'((x_reg + 34'sd32768) >>> 16);
    assign y_rnd   = 18'((y_reg + 34'sd32768) >>> 16);
    assign x_cl    = clamp_unit(x_rnd);
    assign y_cl    = clamp_unit(y_rnd);
    assign cos_val = neg_reg ? -x_cl : x_cl;
    assign sin_val = neg_reg ? -y_cl : y_cl;

endmodule

// ----- rtl/core/tfu_mac.sv -----
module tfu_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  tfu_pkg::mac_ctrl_t ctrl,
    input  logic signed [31:0] op_a,
    input  logic signed [15:0] op_b,
    input  logic signed [31:0] pos_in,
    output logic signed [31:0] pos_res,
    output logic signed [15:0] vec_res
);
    import tfu_pkg::*;

    logic               prod_vld_reg;
    logic signed [47:0] prod_reg;
    logic signed [47:0] prod_next;
    logic signed [32:0] acc_a_reg, acc_b_reg;
    logic signed [32:0] prod_lo, fin_acc;
    logic signed [33:0] sum, sum_rnd;
    logic signed [47:0] prod_rnd;
    logic signed [34:0] step_d, pos_sum;

    // shared multiplier, product registered
    assign prod_next = op_a * op_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else
            prod_vld_reg <= ctrl.mul_en;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= prod_next;
    end

    // frame products stay well inside 33 bits
    assign prod_lo = prod_reg[32:0];

    // partial sums for the two new axis components
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            MAC_LOAD_A: acc_a_reg <= prod_lo;
            MAC_LOAD_B: acc_b_reg <= -prod_lo;
            default:
            begin
            end
        endcase
    end

    // rotation finish: add second product, round, saturate
    assign fin_acc = (ctrl.op == MAC_FIN_B) ? acc_b_reg : acc_a_reg;
    assign sum     = 34'(fin_acc) + 34'(prod_lo);
    assign sum_rnd = sum + 34'sd8192;
    assign vec_res = prod_vld_reg ? sat16(20'(sum_rnd >>> 14)) : '0;

    // move: rounded step added to position, saturated
    assign prod_rnd = prod_reg + 48'sd8192;
    assign step_d   = 35'(prod_rnd >>> 14);
    assign pos_sum  = 35'(pos_in) + step_d;
    assign pos_res  = sat32(pos_sum);

endmodule

// ----- rtl/core/turtle_frame_update.sv -----
// 3D turtle: keeps a Q16.16 position and a Q2.14 frame (forward, left, up)
// and answers every command with one word carrying the whole updated state.
// A move (func 0) adds amount times forward to the position: 3 products
// go through the single 32x16 multiplier and the last is drained before
// res_valid rises. A turn (func 1..3, amount in degrees) first runs angle
// reduction, a fold, 16 CORDIC iterations and a rounding step in the
// sine/cosine unit, then pushes 12 products through the multiplier.
// Results saturate; the frame is never renormalized. cmd_ready is high
// only while no command is in flight, and the block is ready again the
// cycle after the result word is taken.
module turtle_frame_update (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] amount,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] fwd_x,
    output logic signed [15:0] fwd_y,
    output logic signed [15:0] fwd_z,
    output logic signed [15:0] lft_x,
    output logic signed [15:0] lft_y,
    output logic signed [15:0] lft_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z
);
    import tfu_pkg::*;

    top_state_t state_reg, state_next;

    logic [3:0]         cnt_reg, cnt_next;
    logic [1:0]         func_reg;
    logic signed [31:0] amount_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] vec_reg [3][3];

    logic               accept;
    logic               sc_start, sc_done;
    logic signed [15:0] sc_cos, sc_sin;
    logic [3:0]         n_prod, jc;
    logic               mul_en, cons_en;
    logic [1:0]         a_axis, b_axis, m_axis, m_comp, c_comp, w_axis;
    logic signed [31:0] op_a;
    logic signed [15:0] op_b;
    mac_op_t            c_op;
    mac_ctrl_t          mac_ctrl;
    logic signed [31:0] pos_res;
    logic signed [15:0] vec_res;

    assign accept   = cmd_valid && cmd_ready;
    assign sc_start = accept && (func != FUNC_MOVE);

    // sine and cosine unit
    tfu_sincos u_sincos (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sc_start),
        .amount  (amount),
        .done    (sc_done),
        .cos_val (sc_cos),
        .sin_val (sc_sin)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign n_prod = (func_reg == FUNC_MOVE) ? MOVE_PRODUCTS : TURN_PRODUCTS;

    // command sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                    state_next = (func == FUNC_MOVE) ? T_MAC : T_SINCOS;
            end
            T_SINCOS:
            begin
                if (sc_done)
                    state_next = T_MAC;
            end
            T_MAC:
            begin
                if (cnt_reg == n_prod)
                    state_next = T_OUT;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            T_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // axis pair turned by each command
    always_comb
    begin
        unique case (func_reg)
            FUNC_TURN_LEFT:
            begin
                a_axis = AXIS_UP;
                b_axis = AXIS_FWD;
            end
            FUNC_TURN_FWD:
            begin
                a_axis = AXIS_LFT;
                b_axis = AXIS_UP;
            end
            default:
            begin
                a_axis = AXIS_FWD;
                b_axis = AXIS_LFT;
            end
        endcase
    end

    // product schedule per component: s*a, c*a, s*b, c*b
    assign mul_en  = (state_reg == T_MAC) && (cnt_reg < n_prod);
    assign cons_en = (state_reg == T_MAC) && (cnt_reg != 4'd0);
    assign jc      = cnt_reg - 4'd1;

    always_comb
    begin
        m_axis = AXIS_FWD;
        m_comp = 2'd0;
        op_a   = amount_reg;
        if (func_reg == FUNC_MOVE)
        begin
            if (mul_en)
                m_comp = cnt_reg[1:0];
        end
        else
        begin
            if (mul_en)
                m_comp = cnt_reg[3:2];
            m_axis = cnt_reg[1] ? b_axis : a_axis;
            op_a   = cnt_reg[0] ? 32'(cos_reg) : 32'(sin_reg);
        end
        op_b = vec_reg[m_axis][m_comp];
    end

    // consume the product registered in the previous cycle
    always_comb
    begin
        c_op   = MAC_NONE;
        c_comp = 2'd0;
        if (cons_en)
        begin
            if (func_reg == FUNC_MOVE)
            begin
                c_op   = MAC_MOVE;
                c_comp = jc[1:0];
            end
            else
            begin
                c_comp = jc[3:2];
                unique case (jc[1:0])
                    2'd0:    c_op = MAC_LOAD_B;
                    2'd1:    c_op = MAC_LOAD_A;
                    2'd2:    c_op = MAC_FIN_A;
                    default: c_op = MAC_FIN_B;
                endcase
            end
        end
    end

    assign w_axis          = (c_op == MAC_FIN_B) ? b_axis : a_axis;
    assign mac_ctrl.mul_en = mul_en;
    assign mac_ctrl.op     = c_op;

    tfu_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .op_a    (op_a),
        .op_b    (op_b),
        .pos_in  (pos_reg[c_comp]),
        .pos_res (pos_res),
        .vec_res (vec_res)
    );

    // command and sine/cosine capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            amount_reg <= amount;
        end
        if ((state_reg == T_SINCOS) && sc_done)
        begin
            cos_reg <= sc_cos;
            sin_reg <= sc_sin;
        end
    end

    // turtle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= '0;
                for (int a = 0; a < 3; a++)
                    vec_reg[a][k] <= '0;
            end
            vec_reg[AXIS_FWD][2] <= 16'(UNIT_Q14);
            vec_reg[AXIS_LFT][0] <= 16'(UNIT_Q14);
            vec_reg[AXIS_UP][1]  <= 16'(UNIT_Q14);
        end
        else
        begin
            if (c_op == MAC_MOVE)
                pos_reg[c_comp] <= pos_res;
            if ((c_op == MAC_FIN_A) || (c_op == MAC_FIN_B))
                vec_reg[w_axis][c_comp] <= vec_res;
        end
    end

    assign pos_x = pos_reg[0];
    assign pos_y = pos_reg[1];
    assign pos_z = pos_reg[2];
    assign fwd_x = vec_reg[AXIS_FWD][0];
    assign fwd_y = vec_reg[AXIS_FWD][1];
    assign fwd_z = vec_reg[AXIS_FWD][2];
    assign lft_x = vec_reg[AXIS_LFT][0];
    assign lft_y = vec_reg[AXIS_LFT][1];
    assign lft_z = vec_reg[AXIS_LFT][2];
    assign up_x  = vec_reg[AXIS_UP][0];
    assign up_y  = vec_reg[AXIS_UP][1];
    assign up_z  = vec_reg[AXIS_UP][2];

endmodule

// ----- rtl/core/tfu_checker.sv -----
`include "assert_macros.svh"

module tfu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic [1:0]         func,
    input logic signed [31:0] amount,
    input logic               res_valid,
    input logic               res_ready,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic signed [31:0] pos_z,
    input logic signed [15:0] fwd_x,
    input logic signed [15:0] fwd_y,
    input logic signed [15:0] fwd_z,
    input logic signed [15:0] lft_x,
    input logic signed [15:0] lft_y,
    input logic signed [15:0] lft_z,
    input logic signed [15:0] up_x,
    input logic signed [15:0] up_y,
    input logic signed [15:0] up_z
);

    logic         cmd_wait;
    logic         res_wait;
    logic [33:0]  cmd_word;
    logic [239:0] state_word;

    // waiting words and the bits they carry
    assign cmd_wait   = cmd_valid && !cmd_ready;
    assign res_wait   = res_valid && !res_ready;
    assign cmd_word   = {func, amount};
    assign state_word = {pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z,
                         lft_x, lft_y, lft_z, up_x, up_y, up_z};

    // one command in flight: never ready while a result word waits
    `TFU_ASSERT_IMPLY(a_no_overlap, res_valid, !cmd_ready, "ready while result pending")

    // a pending command word holds
    `TFU_ASSERT_NEXT(a_cmd_hold, cmd_wait, cmd_valid && $stable(cmd_word), "command word changed")

    // a pending result word holds
    `TFU_ASSERT_NEXT(a_res_hold, res_wait, res_valid && $stable(state_word), "result word changed")

    // block returns to ready right after the word is taken
    `TFU_ASSERT_NEXT(a_back_ready, res_valid && res_ready, cmd_ready && !res_valid, "not ready")

    // state only moves while a command is processed
    `TFU_ASSERT_NEXT(a_idle_stable, cmd_ready && !cmd_valid, $stable(state_word), "idle change")

endmodule

bind turtle_frame_update tfu_checker u_tfu_checker (.*);
